[sv/ipv6w_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker package
// Shared beat types, walker state, header type codes and result status codes.
// ----------------------------------------------------------------------------
package ipv6w_pkg;

  localparam logic [16:0] FIXED_HDR_BYTES = 17'd40;
  localparam logic [16:0] LAST_FIXED_POS  = 17'd39;
  localparam logic [16:0] LEN_HI_POS      = 17'd4;
  localparam logic [16:0] LEN_LO_POS      = 17'd5;
  localparam logic [16:0] NEXT_HDR_POS    = 17'd6;
  localparam logic [16:0] POS_MAX         = 17'h1ffff;
  localparam logic [11:0] EXPECT_LEN      = 12'hfff;
  localparam logic [11:0] HDR_UNIT_BYTES  = 12'd8;

  localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
  localparam logic [7:0] NH_ROUTING    = 8'd43;
  localparam logic [7:0] NH_FRAGMENT   = 8'd44;
  localparam logic [7:0] NH_DEST_OPTS  = 8'd60;
  localparam logic [7:0] NH_MOBILITY   = 8'd135;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hffff;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT     = 2'd1,
    STATUS_TRUNCATED = 2'd2,
    STATUS_OVERSIZE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  first_next_header;
    logic [15:0] payload_length;
    logic [12:0] ext_header_count;
    logic [15:0] ext_header_bytes;
    logic [16:0] payload_offset;
  } out_t;

  typedef logic [15:0] cfg_t;

  typedef struct packed {
    logic [16:0] byte_position;
    logic [15:0] length_field;
    logic [7:0]  fixed_next_header;
    logic [16:0] remaining_payload;
    logic [7:0]  current_type;
    logic [11:0] header_bytes_left;
    logic        chain_active;
    logic [12:0] header_count;
    logic [15:0] accepted_bytes;
  } walk_state_t;

  function automatic logic is_ext_type(logic [7:0] t);
    return (t == NH_HOP_BY_HOP) || (t == NH_ROUTING) || (t == NH_FRAGMENT) ||
           (t == NH_DEST_OPTS) || (t == NH_MOBILITY);
  endfunction

endpackage

[sv/ipv6w_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker stream channel
// Valid/ready channel carrying one payload beat of a given type.
// ----------------------------------------------------------------------------
interface ipv6w_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/ipv6w_pipe_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker pipeline register
// One-entry valid/ready register stage; takes a new beat while draining one.
// ----------------------------------------------------------------------------
module ipv6w_pipe_reg #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q;
  T     data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

[sv/ipv6w_walker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker core
// Per-byte fixed header capture, extension chain walk and end-of-packet result.
// ----------------------------------------------------------------------------
module ipv6w_walker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  ipv6w_pkg::cfg_t   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ipv6w_pkg::in_t    in_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ipv6w_pkg::out_t   res_data_o
);

  ipv6w_pkg::walk_state_t st_q, st_d, nxt;
  logic [15:0] max_payload_q;
  logic [7:0]  b;
  logic        eop;
  logic        fire;
  logic [11:0] size;
  logic [11:0] hbl_m1;
  logic [16:0] full_len;

  assign b          = in_data_i.data_byte;
  assign eop        = in_data_i.end_of_packet;
  assign in_ready_o = !eop || res_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign res_valid_o = in_valid_i && eop;

  assign size     = {1'b0, b, 3'b000} + ipv6w_pkg::HDR_UNIT_BYTES;
  assign hbl_m1   = st_q.header_bytes_left - 12'd1;
  assign full_len = ipv6w_pkg::FIXED_HDR_BYTES + {1'b0, nxt.length_field};

  always_comb begin
    nxt = st_q;
    if (st_q.byte_position < ipv6w_pkg::FIXED_HDR_BYTES) begin
      if (st_q.byte_position == ipv6w_pkg::LEN_HI_POS) begin
        nxt.length_field[15:8] = b;
      end
      if (st_q.byte_position == ipv6w_pkg::LEN_LO_POS) begin
        nxt.length_field[7:0] = b;
      end
      if (st_q.byte_position == ipv6w_pkg::NEXT_HDR_POS) begin
        nxt.fixed_next_header = b;
      end
      if (st_q.byte_position == ipv6w_pkg::LAST_FIXED_POS &&
          ipv6w_pkg::is_ext_type(st_q.fixed_next_header)) begin
        nxt.chain_active      = 1'b1;
        nxt.header_bytes_left = '0;
        nxt.remaining_payload = {1'b0, st_q.length_field};
      end
    end else if (st_q.chain_active) begin
      if (st_q.header_bytes_left == '0) begin
        nxt.current_type      = b;
        nxt.header_bytes_left = ipv6w_pkg::EXPECT_LEN;
      end else if (st_q.header_bytes_left == ipv6w_pkg::EXPECT_LEN) begin
        if ({5'b0, size} > st_q.remaining_payload) begin
          nxt.chain_active      = 1'b0;
          nxt.header_bytes_left = '0;
        end else begin
          nxt.remaining_payload = st_q.remaining_payload - {5'b0, size};
          nxt.header_count      = st_q.header_count + 13'd1;
          nxt.accepted_bytes    = st_q.accepted_bytes + {4'b0, size};
          nxt.header_bytes_left = size - 12'd2;
        end
      end else begin
        nxt.header_bytes_left = hbl_m1;
        if (hbl_m1 == '0 && !ipv6w_pkg::is_ext_type(st_q.current_type)) begin
          nxt.chain_active = 1'b0;
        end
      end
    end
    if (st_q.byte_position != ipv6w_pkg::POS_MAX) begin
      nxt.byte_position = st_q.byte_position + 17'd1;
    end
  end

  always_comb begin
    res_data_o = '0;
    if (nxt.byte_position < ipv6w_pkg::FIXED_HDR_BYTES) begin
      res_data_o.status = ipv6w_pkg::STATUS_SHORT;
    end else begin
      res_data_o.first_next_header = nxt.fixed_next_header;
      res_data_o.payload_length    = nxt.length_field;
      res_data_o.payload_offset    = ipv6w_pkg::FIXED_HDR_BYTES;
      if (nxt.byte_position < full_len) begin
        res_data_o.status = ipv6w_pkg::STATUS_TRUNCATED;
      end else if (nxt.length_field > max_payload_q) begin
        res_data_o.status = ipv6w_pkg::STATUS_OVERSIZE;
      end else begin
        res_data_o.status           = ipv6w_pkg::STATUS_OK;
        res_data_o.ext_header_count = nxt.header_count;
        res_data_o.ext_header_bytes = nxt.accepted_bytes;
        res_data_o.payload_offset   = ipv6w_pkg::FIXED_HDR_BYTES +
                                      {1'b0, nxt.accepted_bytes};
      end
    end
  end

  // clear the walk after the last byte of a packet
  assign st_d = eop ? '0 : nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= '0;
      max_payload_q <= ipv6w_pkg::MAX_PAYLOAD_RESET;
    end else begin
      if (fire) begin
        st_q <= st_d;
      end
      if (cfg_valid_i) begin
        max_payload_q <= cfg_data_i;
      end
    end
  end

endmodule

[sv/ipv6_extension_header_walker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker
// Byte-stream IPv6 header parser reporting extension chain length per packet.
// ----------------------------------------------------------------------------
// Packet bytes enter one beat per cycle in wire order, with end_of_packet on
// the last byte. Each byte passes an input register, then the walker updates
// its per-packet state, so a new byte is taken every cycle unless input
// stalls. One result beat leaves through a result register after the last
// byte of a packet; input stalls only while that register holds a result the
// sink has not taken and another last byte is waiting. max_payload_bytes is
// written through the configuration channel, which is always ready.
module ipv6_extension_header_walker_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  ipv6w_stream_if.sink   in_i,
  ipv6w_stream_if.source out_o,
  ipv6w_stream_if.sink   cfg_i
);

  logic            s1_valid;
  logic            s1_ready;
  ipv6w_pkg::in_t  s1_data;
  logic            res_valid;
  logic            res_ready;
  ipv6w_pkg::out_t res_data;

  assign cfg_i.ready = 1'b1;

  ipv6w_pipe_reg #(
    .T(ipv6w_pkg::in_t)
  ) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (in_i.payload),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  ipv6w_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.payload),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_data_i   (s1_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  ipv6w_pipe_reg #(
    .T(ipv6w_pkg::out_t)
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .ready_o (res_ready),
    .data_i  (res_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_o.payload)
  );

endmodule

[sv/ipv6w_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
module ipv6w_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input ipv6w_pkg::out_t out_data_i
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == ipv6w_pkg::STATUS_SHORT |->
      out_data_i.first_next_header == '0 && out_data_i.payload_length == '0 &&
      out_data_i.ext_header_count == '0 && out_data_i.ext_header_bytes == '0 &&
      out_data_i.payload_offset == '0)
    else $error("short packet result carries nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == ipv6w_pkg::STATUS_TRUNCATED ||
                    out_data_i.status == ipv6w_pkg::STATUS_OVERSIZE) |->
      out_data_i.ext_header_count == '0 && out_data_i.ext_header_bytes == '0 &&
      out_data_i.payload_offset == ipv6w_pkg::FIXED_HDR_BYTES)
    else $error("rejected packet result reports extension headers");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == ipv6w_pkg::STATUS_OK |->
      out_data_i.payload_offset ==
        ipv6w_pkg::FIXED_HDR_BYTES + {1'b0, out_data_i.ext_header_bytes} &&
      out_data_i.ext_header_bytes <= out_data_i.payload_length)
    else $error("payload offset inconsistent with extension bytes");

endmodule

bind ipv6_extension_header_walker_top ipv6w_checker u_ipv6w_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.payload)
);
